@@ sv/hve_pkg.sv @@
// Shared types and constants for the Hessian value encoder.
`default_nettype none
package hve_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

	localparam logic [2:0] CMD_INT      = 3'd0;
	localparam logic [2:0] CMD_LONG     = 3'd1;
	localparam logic [2:0] CMD_STR_HDR  = 3'd2;
	localparam logic [2:0] CMD_STR_CHAR = 3'd3;
	localparam logic [2:0] CMD_BIN_HDR  = 3'd4;
	localparam logic [2:0] CMD_RAW      = 3'd5;

	localparam logic [7:0] TAG_NULL   = 8'h4e; // 'N'
	localparam logic [7:0] TAG_BINARY = 8'h42; // 'B'
	localparam logic [7:0] TAG_STRING = 8'h53; // 'S'
	localparam logic [7:0] TAG_INT    = 8'h49; // 'I'
	localparam logic [7:0] TAG_LONG   = 8'h4c; // 'L'

	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF8_LEAD3 = 8'he0;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

	typedef struct packed {
		frame_bytes_t     bytes; // bytes[0] goes out first
		logic [CNT_W-1:0] cnt;
	} frame_t;

endpackage
`default_nettype wire

@@ sv/hve_token_if.sv @@
// Input channel: one typed token per item.
`default_nettype none
interface hve_token_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [63:0] value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface
`default_nettype wire

@@ sv/hve_byte_if.sv @@
// Output channel: one wire byte per item with an end-of-token flag.
`default_nettype none
interface hve_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

@@ sv/hve_encode.sv @@
// Combinational token encoder: builds the full byte frame for one token.
`default_nettype none
module hve_encode
	import hve_pkg::*;
(
	input  wire logic [2:0]         cmd,
	input  wire logic signed [63:0] value,
	output frame_t                  frame
);

	logic [15:0] unit;

	assign unit = value[15:0];

	always_comb begin
		frame = '0;
		case (cmd)
			CMD_INT: begin
				frame.bytes[0] = TAG_INT;
				for (int i = 0; i < 4; i++) begin
					frame.bytes[i+1] = value[8*(3-i) +: 8];
				end
				frame.cnt = CNT_W'(5);
			end
			CMD_LONG: begin
				frame.bytes[0] = TAG_LONG;
				for (int i = 0; i < 8; i++) begin
					frame.bytes[i+1] = value[8*(7-i) +: 8];
				end
				frame.cnt = CNT_W'(9);
			end
			CMD_STR_HDR, CMD_BIN_HDR: begin
				if (value == '0) begin
					frame.bytes[0] = TAG_NULL;
					frame.cnt      = CNT_W'(1);
				end else begin
					frame.bytes[0] = (cmd == CMD_STR_HDR) ? TAG_STRING : TAG_BINARY;
					frame.bytes[1] = value[15:8];
					frame.bytes[2] = value[7:0];
					frame.cnt      = CNT_W'(3);
				end
			end
			CMD_STR_CHAR: begin
				if (unit[15:7] == '0) begin
					frame.bytes[0] = {1'b0, unit[6:0]};
					frame.cnt      = CNT_W'(1);
				end else if (unit[15:11] == '0) begin
					frame.bytes[0] = UTF8_LEAD2 | {3'b000, unit[10:6]};
					frame.bytes[1] = UTF8_CONT | {2'b00, unit[5:0]};
					frame.cnt      = CNT_W'(2);
				end else begin
					frame.bytes[0] = UTF8_LEAD3 | {4'b0000, unit[15:12]};
					frame.bytes[1] = UTF8_CONT | {2'b00, unit[11:6]};
					frame.bytes[2] = UTF8_CONT | {2'b00, unit[5:0]};
					frame.cnt      = CNT_W'(3);
				end
			end
			CMD_RAW: begin
				frame.bytes[0] = value[7:0];
				frame.cnt      = CNT_W'(1);
			end
			default: begin
				frame = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/hve_frame.sv @@
// Frame register: holds one encoded token, shifts out a byte per cycle while ready.
`default_nettype none
module hve_frame
	import hve_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load_valid,
	input  wire frame_t load_frame,
	output logic        load_ok,
	hve_byte_if.source  stream
);

	frame_bytes_t     bytes_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic             load;

	assign pop     = stream.valid && stream.ready;
	assign load_ok = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop);
	assign load    = load_valid && load_ok;

	assign stream.valid    = (cnt_q != '0);
	assign stream.out_byte = bytes_q[0];
	assign stream.last     = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_frame.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_frame.bytes;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[FRAME_BYTES-1:1]};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_BYTES))
		else $error("frame count out of range");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load && cnt_q > CNT_W'(1)) |=> (stream.out_byte == $past(bytes_q[1])))
		else $error("frame did not advance by one byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && !stream.last) |-> !load)
		else $error("frame loaded while bytes remain");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop && !load) |=> ($stable(cnt_q)))
		else $error("frame count changed without pop or load");

endmodule
`default_nettype wire

@@ sv/hessian_value_encoder_unit.sv @@
// Top level of the Hessian 1.0 value encoder.
// Each accepted token is captured in an input register, encoded in one pass into a
// frame of up to nine bytes, and sent out one byte per cycle while the sink is ready,
// with last set on the final byte of the token. A token has five bytes for an int,
// nine for a long, one or three for a header, one to three for a character and one
// for a raw byte; unused commands send nothing but are still loaded into the frame
// register. The output frame register, sending one byte a cycle while ready is high,
// sets the sustained rate; a new token is taken while the previous one drains.
`default_nettype none
module hessian_value_encoder_unit
	import hve_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hve_token_if.sink  token,
	hve_byte_if.source stream
);

	logic               valid_s1;
	logic [2:0]         cmd_s1;
	logic signed [63:0] value_s1;
	frame_t             enc_frame;
	logic               load_ok;
	logic               take;

	assign token.ready = !valid_s1 || load_ok;
	assign take        = token.valid && token.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (token.ready) begin
			valid_s1 <= token.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1   <= token.cmd;
			value_s1 <= token.value;
		end
	end

	hve_encode u_encode (
		.cmd   (cmd_s1),
		.value (value_s1),
		.frame (enc_frame)
	);

	hve_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_frame (enc_frame),
		.load_ok    (load_ok),
		.stream     (stream)
	);

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> token.ready)
		else $error("input stage empty but not ready");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted item not held in input stage");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_ok) |=> (valid_s1 && $stable(cmd_s1) && $stable(value_s1)))
		else $error("input stage lost an item while stalled");

endmodule
`default_nettype wire
